FILE: src/cpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pkg
// Types and constants shared by the countdown timer core and its submodules.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_TIME_SET  = 3'd1;
  localparam logic [2:0] MODE_COUNTDOWN = 3'd2;
  localparam logic [2:0] MODE_PAUSE     = 3'd3;
  localparam logic [2:0] MODE_STAT      = 3'd4;

  localparam logic [2:0] EV_INC    = 3'd0;
  localparam logic [2:0] EV_DEC    = 3'd1;
  localparam logic [2:0] EV_START  = 3'd2;
  localparam logic [2:0] EV_CANCEL = 3'd3;
  localparam logic [2:0] EV_TICK   = 3'd4;

  localparam logic [1:0] ST_IGNORED    = 2'd0;
  localparam logic [1:0] ST_HANDLED    = 2'd1;
  localparam logic [1:0] ST_TRANSITION = 2'd2;

  localparam logic [1:0] REG_STEP_SECONDS    = 2'd0;
  localparam logic [1:0] REG_BEEP_PHASE      = 2'd1;
  localparam logic [1:0] REG_COUNT_PHASE     = 2'd2;
  localparam logic [1:0] REG_STAT_HOLD_TICKS = 2'd3;

  localparam logic [11:0] STEP_SECONDS_RST    = 12'd60;
  localparam logic [3:0]  BEEP_PHASE_RST      = 4'd5;
  localparam logic [3:0]  COUNT_PHASE_RST     = 4'd10;
  localparam logic [7:0]  STAT_HOLD_TICKS_RST = 8'd30;

  localparam logic [15:0] SET_MAX = 16'd59999;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] sub_sec;
  } cpt_in_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  status;
    logic [15:0] remaining_time;
    logic [31:0] productive_time;
    logic        beep;
  } cpt_out_t;

  typedef struct packed {
    logic [11:0] step_seconds;
    logic [3:0]  beep_phase;
    logic [3:0]  count_phase;
    logic [7:0]  stat_hold_ticks;
  } cpt_cfg_t;

endpackage

FILE: src/countdown_productivity_timer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_productivity_timer_core
// Five-mode countdown timer with pause and productive-time statistics.
// ----------------------------------------------------------------------------
// Each event beat on the input channel yields exactly one result beat. An
// event is captured in an input register, and the mode update is done
// combinationally between that register and the result register, which
// presents the result; the update waits while a held result is not taken.
// The block takes one event per clock when the result side keeps up; the
// input register can take a new event while a finished result still waits
// in the result register. Configuration writes are always ready and should
// be issued only while no event is in flight.
module countdown_productivity_timer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpt_pkg::cpt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cpt_pkg::cpt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data
);
  import cpt_pkg::*;

  cpt_cfg_t cfg;
  cpt_in_t  item_r;
  logic     item_valid_r;
  cpt_out_t res;
  cpt_out_t out_r;
  logic     out_valid_r;
  logic     adv;

  assign adv       = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  cpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cpt_mode_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid_r <= 1'b1;
      end else if (adv) begin
        item_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

endmodule

FILE: src/cpt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_cfg_regs
// Configuration register file written through the cfg write channel.
// ----------------------------------------------------------------------------
module cpt_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data,
  output cpt_pkg::cpt_cfg_t cfg
);
  import cpt_pkg::*;

  cpt_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_seconds    <= STEP_SECONDS_RST;
      cfg_r.beep_phase      <= BEEP_PHASE_RST;
      cfg_r.count_phase     <= COUNT_PHASE_RST;
      cfg_r.stat_hold_ticks <= STAT_HOLD_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_SECONDS:    cfg_r.step_seconds    <= cfg_data;
        REG_BEEP_PHASE:      cfg_r.beep_phase      <= cfg_data[3:0];
        REG_COUNT_PHASE:     cfg_r.count_phase     <= cfg_data[3:0];
        REG_STAT_HOLD_TICKS: cfg_r.stat_hold_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/cpt_mode_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_mode_ctrl
// Timer state registers and the per-event mode and counter update.
// ----------------------------------------------------------------------------
module cpt_mode_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  cpt_pkg::cpt_in_t  item,
  input  cpt_pkg::cpt_cfg_t cfg,
  output cpt_pkg::cpt_out_t res
);
  import cpt_pkg::*;

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] set_r, set_nxt;
  logic [15:0] elap_r, elap_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [7:0]  cnt_r, cnt_nxt;

  always_comb begin
    logic [16:0] add_sum;
    logic [15:0] added;
    logic [15:0] step_ext;
    logic        can_dec;
    logic [15:0] dec_val;
    logic [32:0] prod_sum;
    logic [15:0] set_tmp;
    logic [7:0]  cnt_inc;
    logic [2:0]  next_mode;
    logic        go;
    logic [1:0]  status;
    logic        beep;

    step_ext  = {4'd0, cfg.step_seconds};
    add_sum   = {1'b0, set_r} + {1'b0, step_ext};
    added     = (add_sum > {1'b0, SET_MAX}) ? SET_MAX : add_sum[15:0];
    can_dec   = (set_r >= step_ext);
    dec_val   = set_r - step_ext;
    set_tmp   = set_r - 16'd1;
    cnt_inc   = cnt_r + 8'd1;
    prod_sum  = 33'd0;
    mode_nxt  = mode_r;
    set_nxt   = set_r;
    elap_nxt  = elap_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    next_mode = mode_r;
    go        = 1'b0;
    status    = ST_IGNORED;
    beep      = 1'b0;

    case (mode_r)
      MODE_IDLE: begin
        if (item.kind == EV_INC) begin
          set_nxt = added; next_mode = MODE_TIME_SET; go = 1'b1;
        end else if (item.kind == EV_START) begin
          next_mode = MODE_STAT; go = 1'b1;
        end else if (item.kind == EV_TICK && item.sub_sec == cfg.beep_phase) begin
          beep = 1'b1; status = ST_HANDLED;
        end
      end
      MODE_TIME_SET: begin
        if (item.kind == EV_INC) begin
          set_nxt = added; status = ST_HANDLED;
        end else if (item.kind == EV_DEC) begin
          if (can_dec) begin
            set_nxt = dec_val; status = ST_HANDLED;
          end
        end else if (item.kind == EV_START) begin
          if (can_dec) begin
            next_mode = MODE_COUNTDOWN; go = 1'b1;
          end
        end else if (item.kind == EV_CANCEL) begin
          next_mode = MODE_IDLE; go = 1'b1;
        end
      end
      MODE_COUNTDOWN: begin
        if (item.kind == EV_START) begin
          next_mode = MODE_PAUSE; go = 1'b1;
        end else if (item.kind == EV_CANCEL) begin
          next_mode = MODE_IDLE; go = 1'b1;
        end else if (item.kind == EV_TICK && item.sub_sec == cfg.count_phase) begin
          if (set_r != 16'd0) begin
            set_nxt = set_tmp;
            if (elap_r != 16'hFFFF) elap_nxt = elap_r + 16'd1;
          end
          if (set_r == 16'd0 || set_tmp == 16'd0) begin
            next_mode = MODE_IDLE; go = 1'b1;
          end else begin
            status = ST_HANDLED;
          end
        end
      end
      MODE_PAUSE: begin
        if (item.kind == EV_INC) begin
          set_nxt = added; next_mode = MODE_TIME_SET; go = 1'b1;
        end else if (item.kind == EV_DEC) begin
          if (can_dec) begin
            set_nxt = dec_val; next_mode = MODE_TIME_SET; go = 1'b1;
          end
        end else if (item.kind == EV_START) begin
          next_mode = MODE_COUNTDOWN; go = 1'b1;
        end else if (item.kind == EV_CANCEL) begin
          next_mode = MODE_IDLE; go = 1'b1;
        end
      end
      default: begin
        if (item.kind == EV_TICK) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc == cfg.stat_hold_ticks) begin
            cnt_nxt = 8'd0; next_mode = MODE_IDLE; go = 1'b1;
          end
        end
      end
    endcase

    if (go) begin
      if (mode_r == MODE_COUNTDOWN) begin
        prod_sum = {1'b0, prod_r} + {17'd0, elap_nxt};
        prod_nxt = prod_sum[32] ? 32'hFFFF_FFFF : prod_sum[31:0];
        elap_nxt = 16'd0;
      end
      if (next_mode == MODE_IDLE) begin
        set_nxt  = 16'd0;
        elap_nxt = 16'd0;
      end
      mode_nxt = next_mode;
      status   = ST_TRANSITION;
    end

    res.mode            = mode_nxt;
    res.status          = status;
    res.remaining_time  = set_nxt;
    res.productive_time = prod_nxt;
    res.beep            = beep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      set_r  <= 16'd0;
      elap_r <= 16'd0;
      prod_r <= 32'd0;
      cnt_r  <= 8'd0;
    end else if (en) begin
      mode_r <= mode_nxt;
      set_r  <= set_nxt;
      elap_r <= elap_nxt;
      prod_r <= prod_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
